// File: design/ufd_pkg.sv
// Shared types, status codes and lead-byte decode for the UTF-8 four-character-code decoder.
`timescale 1ns / 1ps
package ufd_pkg;

  localparam int unsigned CODE_SLOTS = 4;
  localparam int unsigned ACC_W      = 31;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_SHORT = 3'd1,
    STAT_LEAD  = 3'd2,
    STAT_CONT  = 3'd3,
    STAT_BIG   = 3'd4
  } status_t;

  typedef logic [CODE_SLOTS-1:0][7:0] code_t;

  // per-string decode state
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [2:0]       rem;
    logic [1:0]       slot;
    code_t            code;
    status_t          fst;
    logic             finished;
  } str_state_t;

  typedef struct packed {
    code_t   code;
    status_t status;
  } result_t;

  // working record inside one decode step
  typedef struct packed {
    str_state_t s;
    logic       emit;
    logic       zero;
  } step_t;

  localparam str_state_t STR_CLEAR = '{
    acc: '0, rem: '0, slot: '0, code: '0, fst: STAT_OK, finished: 1'b0
  };

  localparam str_state_t STR_RESET = '{
    acc: '0, rem: '0, slot: '0, code: '0, fst: STAT_OK, finished: 1'b1
  };

  // sequence length from the lead byte; 0 marks a bad lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    unique casez (b)
      8'b0???_????: n = 3'd1;
      8'b10??_????: n = 3'd0;
      8'b110?_????: n = 3'd2;
      8'b1110_????: n = 3'd3;
      8'b1111_0???: n = 3'd4;
      8'b1111_10??: n = 3'd5;
      8'b1111_110?: n = 3'd6;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: design/ufd_in_if.sv
// Input channel: one string byte per word.
`timescale 1ns / 1ps
interface ufd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// File: design/ufd_out_if.sv
// Result channel: four code bytes and a status per word.
`timescale 1ns / 1ps
interface ufd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte0;
  logic [7:0] code_byte1;
  logic [7:0] code_byte2;
  logic [7:0] code_byte3;
  logic [2:0] status;

  modport source (output valid, output code_byte0, output code_byte1, output code_byte2,
                  output code_byte3, output status, input ready);
  modport sink   (input valid, input code_byte0, input code_byte1, input code_byte2,
                  input code_byte3, input status, output ready);
endinterface

// File: design/ufd_step.sv
// Combinational single-byte decode step: current string state and one byte in, next state out.
`timescale 1ns / 1ps
module ufd_step (
  input  ufd_pkg::str_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                strict,
  output ufd_pkg::str_state_t st_nxt,
  output logic                emit,
  output ufd_pkg::result_t    res
);
  import ufd_pkg::*;

  function automatic step_t do_finish(input step_t x, input logic zeroed,
                                      input status_t code);
    step_t y;
    y = x;
    if (code != STAT_OK && y.s.fst == STAT_OK) y.s.fst = code;
    y.zero       = zeroed;
    y.s.finished = 1'b1;
    y.emit       = 1'b1;
    return y;
  endfunction

  function automatic step_t store_char(input step_t x, input logic [ACC_W-1:0] v,
                                       input logic strict_i);
    step_t y;
    logic  big;
    y   = x;
    big = |v[ACC_W-1:8];
    if (big && strict_i) return do_finish(y, 1'b1, STAT_BIG);
    if (big && y.s.fst == STAT_OK) y.s.fst = STAT_BIG;
    y.s.code[y.s.slot] = v[7:0];
    if (y.s.slot == 2'd3) y = do_finish(y, 1'b0, STAT_OK);
    else                  y.s.slot = y.s.slot + 2'd1;
    return y;
  endfunction

  function automatic step_t lead_step(input step_t x, input logic [7:0] b,
                                      input logic strict_i);
    step_t      y;
    logic [2:0] n;
    y = x;
    n = lead_len(b);
    if (b == 8'h00) return do_finish(y, strict_i, STAT_SHORT);
    if (!b[7]) return store_char(y, {{(ACC_W-8){1'b0}}, b}, strict_i);
    if (n == 3'd0) begin
      if (strict_i) return do_finish(y, 1'b1, STAT_LEAD);
      if (y.s.fst == STAT_OK) y.s.fst = STAT_LEAD;
      return y;
    end
    // lead keeps its low 7-n bits
    y.s.acc = {{(ACC_W-8){1'b0}}, b & (8'hFF >> 3'(n + 3'd1))};
    y.s.rem = n - 3'd1;
    return y;
  endfunction

  step_t x;
  step_t y;

  always_comb begin
    x.s    = first_byte ? STR_CLEAR : st;
    x.emit = 1'b0;
    x.zero = 1'b0;
    if (!first_byte && st.finished) begin
      y = x;
    end else if (x.s.rem != 3'd0) begin
      if (data_byte[7:6] == 2'b10) begin
        x.s.acc = {x.s.acc[ACC_W-7:0], data_byte[5:0]};
        x.s.rem = x.s.rem - 3'd1;
        y = (x.s.rem == 3'd0) ? store_char(x, x.s.acc, strict) : x;
      end else begin
        x.s.rem = 3'd0;
        if (strict) begin
          y = do_finish(x, 1'b1, STAT_CONT);
        end else begin
          // keep the partial char, then retry the byte as a lead
          if (x.s.fst == STAT_OK) x.s.fst = STAT_CONT;
          x = store_char(x, x.s.acc, strict);
          y = x.emit ? x : lead_step(x, data_byte, strict);
        end
      end
    end else begin
      y = lead_step(x, data_byte, strict);
    end
  end

  assign st_nxt     = y.s;
  assign emit       = y.emit;
  assign res.code   = y.zero ? '0 : y.s.code;
  assign res.status = y.s.fst;

endmodule

// File: design/utf8_fourcc_decoder.sv
// Top level: input register, decode step and result register of the UTF-8 code decoder.
//
// Usage:
//   in_if  (sink):   one string byte per word; first_byte=1 starts a new string and
//                    drops any string in progress. A zero byte ends the string.
//   out_if (source): one word per string with four code bytes and a status, given
//                    when four characters are decoded, at the NUL, or at a strict error.
//   cfg_we/cfg_data: writes strict_mode (reset 1); write only while the block is idle.
// A byte passes from the input register through the decode step; its result goes to the result register.
// Throughput: one byte per cycle while no result is stalled on out_if; the string
// state feeds back from its register through the decode step.
// Reset: both pipeline registers empty, strict mode on, and the decoder waits for a
// start flag; bytes without one are dropped.
// Stall: while out_if.ready is low and a result is held, the decode stage stops and
// one more byte is held in the input register before in_if.ready falls.
`timescale 1ns / 1ps
module utf8_fourcc_decoder (
  input logic        clk,
  input logic        rst_n,
  ufd_in_if.sink     in_if,
  ufd_out_if.source  out_if,
  input logic        cfg_we,
  input logic        cfg_data
);
  import ufd_pkg::*;

  logic       strict_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  str_state_t st_r;
  str_state_t st_nxt;
  logic       step_emit;
  result_t    step_res;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       adv;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = !in_valid_r || adv;

  ufd_step u_step (
    .st         (st_r),
    .data_byte  (in_byte_r),
    .first_byte (in_first_r),
    .strict     (strict_r),
    .st_nxt     (st_nxt),
    .emit       (step_emit),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r    <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STR_RESET;
    end else begin
      if (cfg_we) strict_r <= cfg_data;
      if (in_if.ready) in_valid_r <= in_if.valid;
      if (in_valid_r && adv) st_r <= st_nxt;
      if (adv) out_valid_r <= in_valid_r && step_emit;
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r  <= in_if.data_byte;
      in_first_r <= in_if.first_byte;
    end
    if (adv && in_valid_r && step_emit) out_res_r <= step_res;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.code_byte0 = out_res_r.code[0];
  assign out_if.code_byte1 = out_res_r.code[1];
  assign out_if.code_byte2 = out_res_r.code[2];
  assign out_if.code_byte3 = out_res_r.code[3];
  assign out_if.status     = out_res_r.status;

  // a partly decoded character never sits in a finished string
  a_rem_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem != 3'd0 |-> !st_r.finished)
    else $error("continuation pending in finished string");

  // every emitted result closes the string and lands in the output register
  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_valid_r && step_emit) |=> (st_r.finished && out_valid_r))
    else $error("result emitted without closing string");

  // input only backs up when both registers are full and the sink stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (in_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled without downstream stall");

  // longest pending tail is five continuation bytes
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem <= 3'd5)
    else $error("pending continuation count out of range");

endmodule
